// ===== sv/ecam_pkg.sv =====
// ecam_pkg: shared types, constants and tables for the fly camera block
// no dependencies; used by the channel interfaces and all camera modules
package ecam_pkg;

	localparam int POS_W = 32;
	localparam int VEC_W = 16;
	localparam int ANG_W = 15;
	localparam int ZOOM_W = 14;
	localparam int TRIG_W = 32;
	localparam int ZACC_W = 26;
	localparam int ATAN_W = 22;
	localparam int SQ_W = 64;
	localparam int LEN_W = 32;
	localparam int NUM_W = 47;
	localparam int QUO_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int ATAN_COUNT = 24;

	localparam logic [1:0] MODE_MOVE = 2'd0;
	localparam logic [1:0] MODE_LOOK = 2'd1;
	localparam logic [1:0] MODE_ZOOM = 2'd2;

	localparam logic [2:0] DIR_BACK = 3'd1;
	localparam logic [2:0] DIR_LEFT = 3'd3;
	localparam logic [2:0] DIR_DOWN = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_SENS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_MOVE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_LOOK = 2'd3;

	localparam logic [15:0] SENS_RESET = 16'd6554;
	localparam logic [15:0] SPEED_RESET = 16'd640;

	localparam logic signed [15:0] ANG_WRAP = 16'sd23040;
	localparam logic signed [15:0] ANG_HALF = 16'sd11520;
	localparam logic signed [15:0] ANG_HALF_NEG = -16'sd11520;
	localparam logic signed [15:0] ANG_QUARTER = 16'sd5760;
	localparam logic signed [15:0] ANG_QUARTER_NEG = -16'sd5760;
	localparam logic signed [15:0] PITCH_LIMIT = 16'sd5696;
	localparam logic signed [15:0] PITCH_LIMIT_NEG = -16'sd5696;

	localparam logic [ZOOM_W-1:0] ZOOM_MIN = 14'd256;
	localparam logic [ZOOM_W-1:0] ZOOM_MAX = 14'd11520;

	localparam logic signed [VEC_W-1:0] UNIT_Q14 = 16'sd16384;
	localparam logic signed [TRIG_W-1:0] CORDIC_K = 32'sd652032874;

	// atan(2^-i) in degrees times 2^16
	function automatic logic [ATAN_W-1:0] atan_deg16(input logic [4:0] idx);
		logic [ATAN_W-1:0] v;
		case (idx)
			5'd0: v = 22'd2949120;
			5'd1: v = 22'd1740967;
			5'd2: v = 22'd919879;
			5'd3: v = 22'd466945;
			5'd4: v = 22'd234379;
			5'd5: v = 22'd117304;
			5'd6: v = 22'd58666;
			5'd7: v = 22'd29334;
			5'd8: v = 22'd14668;
			5'd9: v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/ecam_if.sv =====
// ecam_if: valid/ready channel interfaces for commands, results and config
// depends on ecam_pkg
interface ecam_cmd_if import ecam_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] mode;
	logic [2:0] move_dir;
	logic [15:0] time_step;
	logic signed [15:0] x_offset;
	logic signed [15:0] y_offset;
	logic clamp_pitch;
	modport source(output valid, mode, move_dir, time_step, x_offset, y_offset, clamp_pitch,
		input ready);
	modport sink(input valid, mode, move_dir, time_step, x_offset, y_offset, clamp_pitch,
		output ready);
endinterface

interface ecam_res_if import ecam_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic signed [VEC_W-1:0] front_x;
	logic signed [VEC_W-1:0] front_y;
	logic signed [VEC_W-1:0] front_z;
	logic signed [VEC_W-1:0] up_x;
	logic signed [VEC_W-1:0] up_y;
	logic signed [VEC_W-1:0] up_z;
	logic [ZOOM_W-1:0] zoom_out;
	logic signed [ANG_W-1:0] yaw_out;
	logic signed [ANG_W-1:0] pitch_out;
	modport source(output valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
		up_x, up_y, up_z, zoom_out, yaw_out, pitch_out, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, front_x, front_y, front_z,
		up_x, up_y, up_z, zoom_out, yaw_out, pitch_out, output ready);
endinterface

interface ecam_cfg_if import ecam_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface

// ===== sv/ecam_cordic.sv =====
// ecam_cordic: iterative rotation cordic, one micro-rotation per cycle
// depends on ecam_pkg for widths, gain and the atan table
module ecam_cordic import ecam_pkg::*; #(
	parameter int ITERATIONS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [ANG_W-1:0]  ang,
	output logic                     done,
	output logic signed [TRIG_W-1:0] cos_o,
	output logic signed [TRIG_W-1:0] sin_o
);
	localparam int NI = (ITERATIONS > ATAN_COUNT) ? ATAN_COUNT : ITERATIONS;
	localparam int IW = $clog2(NI);

	logic busy_q, done_q, neg_q;
	logic [IW-1:0] i_q;
	logic signed [TRIG_W-1:0] x_q, y_q, xn, yn, c_q, s_q;
	logic signed [ZACC_W-1:0] z_q, zn, at;
	logic signed [15:0] a_in, a_fold;
	logic fold_neg;

	always_comb begin
		a_in = {ang[ANG_W-1], ang};
		a_fold = a_in;
		fold_neg = 1'b0;
		if (a_in > ANG_QUARTER) begin
			a_fold = a_in - ANG_HALF;
			fold_neg = 1'b1;
		end else if (a_in < ANG_QUARTER_NEG) begin
			a_fold = a_in + ANG_HALF;
			fold_neg = 1'b1;
		end
	end

	always_comb begin
		at = $signed({4'b0, atan_deg16(5'(i_q))});
		if (!z_q[ZACC_W-1]) begin
			xn = x_q - (y_q >>> i_q);
			yn = y_q + (x_q >>> i_q);
			zn = z_q - at;
		end else begin
			xn = x_q + (y_q >>> i_q);
			yn = y_q - (x_q >>> i_q);
			zn = z_q + at;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q <= 1'b0;
			i_q <= '0;
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
			c_q <= '0;
			s_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					neg_q <= fold_neg;
					i_q <= '0;
					x_q <= CORDIC_K;
					y_q <= '0;
					z_q <= {a_fold, 10'b0};
				end
			end else begin
				x_q <= xn;
				y_q <= yn;
				z_q <= zn;
				i_q <= i_q + 1'b1;
				if (i_q == IW'(NI - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					c_q <= neg_q ? -xn : xn;
					s_q <= neg_q ? -yn : yn;
				end
			end
		end
	end

	assign done = done_q;
	assign cos_o = c_q;
	assign sin_o = s_q;
endmodule

// ===== sv/ecam_sqrt.sv =====
// ecam_sqrt: bit-pair integer square root, one result bit per cycle
// depends on ecam_pkg for widths
module ecam_sqrt import ecam_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SQ_W-1:0]  val,
	output logic             done,
	output logic [LEN_W-1:0] root
);
	logic busy_q, done_q;
	logic [SQ_W-1:0] v_q, r_q, b_q, t, vn, rn;
	logic [LEN_W-1:0] root_q;

	always_comb begin
		t = r_q + b_q;
		if (v_q >= t) begin
			vn = v_q - t;
			rn = (r_q >> 1) + b_q;
		end else begin
			vn = v_q;
			rn = r_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			v_q <= '0;
			r_q <= '0;
			b_q <= '0;
			root_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					v_q <= val;
					r_q <= '0;
					b_q <= {2'b01, {(SQ_W-2){1'b0}}};
				end
			end else begin
				v_q <= vn;
				r_q <= rn;
				b_q <= b_q >> 2;
				if (b_q[0]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					root_q <= rn[LEN_W-1:0];
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

// ===== sv/ecam_div.sv =====
// ecam_div: restoring divider for vector normalization, one quotient bit per cycle
// depends on ecam_pkg for widths
module ecam_div import ecam_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [LEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);
	logic busy_q, done_q;
	logic [3:0] cnt_q;
	logic [LEN_W:0] rem_q, sh;
	logic [QUO_W-1:0] lo_q, q_q, qn;
	logic [LEN_W-1:0] den_q;

	always_comb begin
		sh = {rem_q[LEN_W-1:0], lo_q[QUO_W-1]};
		qn = {q_q[QUO_W-2:0], 1'b0};
		if (sh >= {1'b0, den_q}) begin
			qn[0] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			rem_q <= '0;
			lo_q <= '0;
			q_q <= '0;
			den_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					cnt_q <= '0;
					rem_q <= {2'b0, num[NUM_W-1:QUO_W]};
					lo_q <= num[QUO_W-1:0];
					q_q <= '0;
					den_q <= den;
				end
			end else begin
				rem_q <= qn[0] ? sh - {1'b0, den_q} : sh;
				lo_q <= lo_q << 1;
				q_q <= qn;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo = q_q;
endmodule

// ===== sv/euler_fly_camera_update.sv =====
// euler_fly_camera_update: fly camera state, sequencer and shared 33x33 multiplier
// depends on ecam_pkg, ecam_if, ecam_cordic, ecam_sqrt, ecam_div
// a look command may repeat the wrap step before the trig and normalization steps
// (one cordic, one sqrt and one divider in turn, three normalizations: front, right, up)
// throughput: one command at a time; a new command is taken while the last result waits
// reset: asynchronous, restores the default pose, zoom 45 and default config
module euler_fly_camera_update import ecam_pkg::*; #(
	parameter int TRIG_ITERATIONS = 16
) (
	input logic          clk,
	input logic          arst_n,
	ecam_cmd_if.sink     cmd,
	ecam_res_if.source   res,
	ecam_cfg_if.sink     cfg
);
	typedef enum logic [4:0] {
		S_IDLE, S_MV_V, S_MV_VQ, S_MV_M, S_MV_A, S_LK_DY, S_LK_DP, S_LK_PC, S_LK_WRAP,
		S_CY_GO, S_CY_WAIT, S_CP_GO, S_CP_WAIT, S_D0, S_D2, S_D3,
		S_N_SQ, S_N_ACC, S_N_SQRT_GO, S_N_SQRT_WAIT, S_N_DIV_GO, S_N_DIV_WAIT, S_N_DONE,
		S_U0, S_U1, S_U2, S_U3, S_U4, S_ZM, S_OUT
	} state_t;

	typedef enum logic [1:0] {T_FRONT, T_RIGHT, T_UP} tgt_t;

	state_t state_q;
	tgt_t tgt_q;

	logic [15:0] sens_q, speed_q;
	logic allow_move_q, allow_look_q;

	logic [1:0] mode_q;
	logic [2:0] dir_q;
	logic [15:0] dt_q;
	logic signed [15:0] xo_q, yo_q;
	logic cl_q;

	logic signed [POS_W-1:0] pos_q [3];
	logic signed [VEC_W-1:0] front_q [3];
	logic signed [VEC_W-1:0] right_q [3];
	logic signed [VEC_W-1:0] up_q [3];
	logic signed [ANG_W-1:0] yaw_q, pitch_q;
	logic [ZOOM_W-1:0] zoom_q;

	logic [1:0] k_q;
	logic [31:0] v_q;
	logic signed [19:0] yaw_acc_q, pitch_acc_q;
	logic signed [TRIG_W-1:0] cy_q, sy_q, cp_q, sp_q, d0_q, d2_q;
	logic signed [TRIG_W-1:0] nv_q [3];
	logic [SQ_W-1:0] acc_q, tmp_q;
	logic [LEN_W-1:0] len_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod_q, rnd_sum, mv_rnd, neg_prod, u1_sum;

	logic res_valid_q;
	logic signed [POS_W-1:0] o_pos_q [3];
	logic signed [VEC_W-1:0] o_front_q [3];
	logic signed [VEC_W-1:0] o_up_q [3];
	logic [ZOOM_W-1:0] o_zoom_q;
	logic signed [ANG_W-1:0] o_yaw_q, o_pitch_q;

	logic cor_start, cor_done, sq_start, sq_done, div_start, div_done;
	logic signed [ANG_W-1:0] cor_ang;
	logic signed [TRIG_W-1:0] cor_c, cor_s;
	logic [LEN_W-1:0] sq_root;
	logic [NUM_W-1:0] div_num;
	logic [QUO_W-1:0] div_quo, qc;
	logic [31:0] mag;
	logic signed [VEC_W-1:0] nval;

	logic signed [VEC_W-1:0] comp;
	logic signed [25:0] step;
	logic signed [26:0] stp;
	logic signed [32:0] newp;
	logic signed [POS_W-1:0] newp_sat;
	logic signed [19:0] yaw_sum, pitch_sum, pitch_clamped;
	logic yaw_ok, pitch_ok;
	logic signed [21:0] zsum, zmin22, zmax22;

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MV_V: begin
				mul_a = {17'b0, speed_q};
				mul_b = {17'b0, dt_q};
			end
			S_MV_M: begin
				mul_a = {1'b0, v_q};
				mul_b = {{17{comp[VEC_W-1]}}, comp};
			end
			S_LK_DY: begin
				mul_a = {{17{xo_q[15]}}, xo_q};
				mul_b = {17'b0, sens_q};
			end
			S_LK_DP: begin
				mul_a = {{17{yo_q[15]}}, yo_q};
				mul_b = {17'b0, sens_q};
			end
			S_D0: begin
				mul_a = {cy_q[TRIG_W-1], cy_q};
				mul_b = {cp_q[TRIG_W-1], cp_q};
			end
			S_D2: begin
				mul_a = {sy_q[TRIG_W-1], sy_q};
				mul_b = {cp_q[TRIG_W-1], cp_q};
			end
			S_N_SQ: begin
				mul_a = {nv_q[k_q][TRIG_W-1], nv_q[k_q]};
				mul_b = {nv_q[k_q][TRIG_W-1], nv_q[k_q]};
			end
			S_U0, S_U3: begin
				mul_a = {(state_q == S_U0) ? d0_q[TRIG_W-1] : d2_q[TRIG_W-1],
					(state_q == S_U0) ? d0_q : d2_q};
				mul_b = {sp_q[TRIG_W-1], sp_q};
			end
			S_U1: begin
				mul_a = {d0_q[TRIG_W-1], d0_q};
				mul_b = {d0_q[TRIG_W-1], d0_q};
			end
			S_U2: begin
				mul_a = {d2_q[TRIG_W-1], d2_q};
				mul_b = {d2_q[TRIG_W-1], d2_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
		end else begin
			prod_q <= mul_a * mul_b;
		end
	end

	// move datapath
	always_comb begin
		if (dir_q <= DIR_BACK) begin
			comp = front_q[k_q];
		end else if (dir_q <= DIR_LEFT) begin
			comp = right_q[k_q];
		end else begin
			comp = (k_q == 2'd1) ? UNIT_Q14 : '0;
		end
		mv_rnd = prod_q + 66'sd2097152;
		step = mv_rnd[47:22];
		stp = dir_q[0] ? -{step[25], step} : {step[25], step};
		newp = {pos_q[k_q][POS_W-1], pos_q[k_q]} + {{6{stp[26]}}, stp};
		if (newp[32] != newp[31]) begin
			newp_sat = newp[32] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			newp_sat = newp[POS_W-1:0];
		end
	end

	// look datapath
	always_comb begin
		rnd_sum = prod_q + 66'sd8192;
		yaw_sum = {{5{yaw_q[ANG_W-1]}}, yaw_q} + rnd_sum[33:14];
		pitch_sum = {{5{pitch_q[ANG_W-1]}}, pitch_q} + rnd_sum[33:14];
		pitch_clamped = pitch_sum;
		if (cl_q) begin
			if (pitch_sum > PITCH_LIMIT) begin
				pitch_clamped = 20'(PITCH_LIMIT);
			end else if (pitch_sum < PITCH_LIMIT_NEG) begin
				pitch_clamped = 20'(PITCH_LIMIT_NEG);
			end
		end
		yaw_ok = (yaw_acc_q >= ANG_HALF_NEG) && (yaw_acc_q < ANG_HALF);
		pitch_ok = (pitch_acc_q >= ANG_HALF_NEG) && (pitch_acc_q < ANG_HALF);
		neg_prod = -prod_q;
		u1_sum = $signed({2'b0, tmp_q}) + prod_q;
	end

	// zoom datapath
	always_comb begin
		zmin22 = $signed({8'b0, ZOOM_MIN});
		zmax22 = $signed({8'b0, ZOOM_MAX});
		zsum = $signed({8'b0, zoom_q}) - $signed({{2{yo_q[15]}}, yo_q, 4'b0});
	end

	// normalization datapath
	always_comb begin
		mag = nv_q[k_q][TRIG_W-1] ? 32'(-nv_q[k_q]) : nv_q[k_q];
		div_num = {1'b0, mag, 14'b0} + {16'b0, len_q[LEN_W-1:1]};
		qc = (div_quo > 16'(UNIT_Q14)) ? 16'(UNIT_Q14) : div_quo;
		nval = nv_q[k_q][TRIG_W-1] ? -$signed(qc) : $signed(qc);
	end

	assign cor_start = (state_q == S_CY_GO) || (state_q == S_CP_GO);
	assign cor_ang = (state_q == S_CP_GO) ? pitch_q : yaw_q;
	assign sq_start = (state_q == S_N_SQRT_GO);
	assign div_start = (state_q == S_N_DIV_GO);

	ecam_cordic #(.ITERATIONS(TRIG_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .ang(cor_ang),
		.done(cor_done), .cos_o(cor_c), .sin_o(cor_s)
	);

	ecam_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .val(acc_q),
		.done(sq_done), .root(sq_root)
	);

	ecam_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(len_q),
		.done(div_done), .quo(div_quo)
	);

	// config registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sens_q <= SENS_RESET;
			speed_q <= SPEED_RESET;
			allow_move_q <= 1'b1;
			allow_look_q <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.idx)
				CFG_SENS: sens_q <= cfg.data;
				CFG_SPEED: speed_q <= cfg.data;
				CFG_ALLOW_MOVE: allow_move_q <= cfg.data[0];
				CFG_ALLOW_LOOK: allow_look_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign cmd.ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_q <= T_FRONT;
			mode_q <= MODE_MOVE;
			dir_q <= '0;
			dt_q <= '0;
			xo_q <= '0;
			yo_q <= '0;
			cl_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				nv_q[i] <= '0;
				o_pos_q[i] <= '0;
				o_front_q[i] <= '0;
				o_up_q[i] <= '0;
			end
			front_q[0] <= '0;
			front_q[1] <= '0;
			front_q[2] <= -UNIT_Q14;
			right_q[0] <= UNIT_Q14;
			right_q[1] <= '0;
			right_q[2] <= '0;
			up_q[0] <= '0;
			up_q[1] <= UNIT_Q14;
			up_q[2] <= '0;
			yaw_q <= ANG_W'(ANG_QUARTER_NEG);
			pitch_q <= '0;
			zoom_q <= ZOOM_MAX;
			k_q <= '0;
			v_q <= '0;
			yaw_acc_q <= '0;
			pitch_acc_q <= '0;
			cy_q <= '0;
			sy_q <= '0;
			cp_q <= '0;
			sp_q <= '0;
			d0_q <= '0;
			d2_q <= '0;
			acc_q <= '0;
			tmp_q <= '0;
			len_q <= '0;
			res_valid_q <= 1'b0;
			o_zoom_q <= '0;
			o_yaw_q <= '0;
			o_pitch_q <= '0;
		end else begin
			if (res_valid_q && res.ready && (state_q != S_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						mode_q <= cmd.mode;
						dir_q <= cmd.move_dir;
						dt_q <= cmd.time_step;
						xo_q <= cmd.x_offset;
						yo_q <= cmd.y_offset;
						cl_q <= cmd.clamp_pitch;
						case (cmd.mode)
							MODE_MOVE: state_q <= (allow_move_q && cmd.move_dir <= DIR_DOWN)
								? S_MV_V : S_OUT;
							MODE_LOOK: state_q <= allow_look_q ? S_LK_DY : S_OUT;
							MODE_ZOOM: state_q <= allow_look_q ? S_ZM : S_OUT;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_MV_V: state_q <= S_MV_VQ;
				S_MV_VQ: begin
					v_q <= prod_q[31:0];
					k_q <= '0;
					state_q <= S_MV_M;
				end
				S_MV_M: state_q <= S_MV_A;
				S_MV_A: begin
					pos_q[k_q] <= newp_sat;
					if (k_q == 2'd2) begin
						state_q <= S_OUT;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_MV_M;
					end
				end
				S_LK_DY: state_q <= S_LK_DP;
				S_LK_DP: begin
					yaw_acc_q <= yaw_sum;
					state_q <= S_LK_PC;
				end
				S_LK_PC: begin
					pitch_acc_q <= pitch_clamped;
					state_q <= S_LK_WRAP;
				end
				S_LK_WRAP: begin
					if (yaw_acc_q >= ANG_HALF) begin
						yaw_acc_q <= yaw_acc_q - ANG_WRAP;
					end else if (yaw_acc_q < ANG_HALF_NEG) begin
						yaw_acc_q <= yaw_acc_q + ANG_WRAP;
					end
					if (pitch_acc_q >= ANG_HALF) begin
						pitch_acc_q <= pitch_acc_q - ANG_WRAP;
					end else if (pitch_acc_q < ANG_HALF_NEG) begin
						pitch_acc_q <= pitch_acc_q + ANG_WRAP;
					end
					if (yaw_ok && pitch_ok) begin
						yaw_q <= yaw_acc_q[ANG_W-1:0];
						pitch_q <= pitch_acc_q[ANG_W-1:0];
						state_q <= S_CY_GO;
					end
				end
				S_CY_GO: state_q <= S_CY_WAIT;
				S_CY_WAIT: begin
					if (cor_done) begin
						cy_q <= cor_c;
						sy_q <= cor_s;
						state_q <= S_CP_GO;
					end
				end
				S_CP_GO: state_q <= S_CP_WAIT;
				S_CP_WAIT: begin
					if (cor_done) begin
						cp_q <= cor_c;
						sp_q <= cor_s;
						state_q <= S_D0;
					end
				end
				S_D0: state_q <= S_D2;
				S_D2: begin
					d0_q <= prod_q[61:30];
					state_q <= S_D3;
				end
				S_D3: begin
					d2_q <= prod_q[61:30];
					nv_q[0] <= d0_q;
					nv_q[1] <= sp_q;
					nv_q[2] <= prod_q[61:30];
					acc_q <= '0;
					k_q <= '0;
					tgt_q <= T_FRONT;
					state_q <= S_N_SQ;
				end
				S_N_SQ: state_q <= S_N_ACC;
				S_N_ACC: begin
					acc_q <= acc_q + prod_q[SQ_W-1:0];
					if (k_q == 2'd2) begin
						state_q <= S_N_SQRT_GO;
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_N_SQ;
					end
				end
				S_N_SQRT_GO: state_q <= S_N_SQRT_WAIT;
				S_N_SQRT_WAIT: begin
					if (sq_done) begin
						len_q <= sq_root;
						k_q <= '0;
						if (sq_root == '0) begin
							for (int i = 0; i < 3; i++) begin
								case (tgt_q)
									T_FRONT: front_q[i] <= '0;
									T_RIGHT: right_q[i] <= '0;
									T_UP: up_q[i] <= '0;
									default: ;
								endcase
							end
							state_q <= S_N_DONE;
						end else begin
							state_q <= S_N_DIV_GO;
						end
					end
				end
				S_N_DIV_GO: state_q <= S_N_DIV_WAIT;
				S_N_DIV_WAIT: begin
					if (div_done) begin
						case (tgt_q)
							T_FRONT: front_q[k_q] <= nval;
							T_RIGHT: right_q[k_q] <= nval;
							T_UP: up_q[k_q] <= nval;
							default: ;
						endcase
						if (k_q == 2'd2) begin
							state_q <= S_N_DONE;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= S_N_DIV_GO;
						end
					end
				end
				S_N_DONE: begin
					case (tgt_q)
						T_FRONT: begin
							nv_q[0] <= -d2_q;
							nv_q[1] <= '0;
							nv_q[2] <= d0_q;
							acc_q <= '0;
							k_q <= '0;
							tgt_q <= T_RIGHT;
							state_q <= S_N_SQ;
						end
						T_RIGHT: state_q <= S_U0;
						default: state_q <= S_OUT;
					endcase
				end
				S_U0: state_q <= S_U1;
				S_U1: begin
					nv_q[0] <= neg_prod[61:30];
					state_q <= S_U2;
				end
				S_U2: begin
					tmp_q <= prod_q[SQ_W-1:0];
					state_q <= S_U3;
				end
				S_U3: begin
					nv_q[1] <= u1_sum[61:30];
					state_q <= S_U4;
				end
				S_U4: begin
					nv_q[2] <= neg_prod[61:30];
					acc_q <= '0;
					k_q <= '0;
					tgt_q <= T_UP;
					state_q <= S_N_SQ;
				end
				S_ZM: begin
					if (zsum < zmin22) begin
						zoom_q <= ZOOM_MIN;
					end else if (zsum > zmax22) begin
						zoom_q <= ZOOM_MAX;
					end else begin
						zoom_q <= zsum[ZOOM_W-1:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							o_pos_q[i] <= pos_q[i];
							o_front_q[i] <= front_q[i];
							o_up_q[i] <= up_q[i];
						end
						o_zoom_q <= zoom_q;
						o_yaw_q <= yaw_q;
						o_pitch_q <= pitch_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res.valid = res_valid_q;
	assign res.pos_x = o_pos_q[0];
	assign res.pos_y = o_pos_q[1];
	assign res.pos_z = o_pos_q[2];
	assign res.front_x = o_front_q[0];
	assign res.front_y = o_front_q[1];
	assign res.front_z = o_front_q[2];
	assign res.up_x = o_up_q[0];
	assign res.up_y = o_up_q[1];
	assign res.up_z = o_up_q[2];
	assign res.zoom_out = o_zoom_q;
	assign res.yaw_out = o_yaw_q;
	assign res.pitch_out = o_pitch_q;

	a_zoom_range: assert property (@(posedge clk) disable iff (!arst_n)
		(zoom_q >= ZOOM_MIN) && (zoom_q <= ZOOM_MAX))
		else $error("zoom left its range");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		(yaw_q >= ANG_HALF_NEG) && (yaw_q < ANG_HALF))
		else $error("yaw not wrapped");

	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == S_CY_WAIT) || (state_q == S_CP_WAIT))
		else $error("cordic finished outside a wait state");
endmodule
